// ===== src/md5_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_pkg: shared types, constants and round tables for the MD5 hasher
// Holds the initial chaining values, the round constant and shift tables,
// the message word schedule and the controller to datapath command types.
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [3:0] LAST_IDX  = 4'd15;

    // Content of the block that is being compressed.
    typedef enum logic [1:0] {
        BLK_DATA,      // all 64 bytes come from the buffer
        BLK_PAD_ONE,   // pending bytes, 0x80, zeros, bit length
        BLK_PAD_FIRST, // pending bytes, 0x80, zeros
        BLK_PAD_LEN    // zeros, bit length
    } md5_mode_t;

    typedef struct packed {
        logic      load_byte;
        logic      start_blk;
        logic      round_en;
        logic      fold;
        logic      reinit;
        md5_mode_t mode;
        logic [5:0] round;
        logic [5:0] rd_round;
        logic [3:0] out_idx;
    } md5_cmd_t;

    typedef struct packed {
        logic pend_hi;   // 56 or more bytes pending
        logic blk_full;  // the next byte fills the block
    } md5_sts_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Message word used by a round.
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] r;
        logic [3:0] g;
        r = i[3:0];
        case (i[5:4])
            2'd0:    g = r;
            2'd1:    g = r + (r << 2) + 4'd1;
            2'd2:    g = r + (r << 1) + 4'd5;
            default: g = (r << 3) - r;
        endcase
        return g;
    endfunction

endpackage

// ===== src/md5_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_ctrl: sequencer of the MD5 hasher
// Accepts items, steps the 64 compression rounds, chooses the padding
// blocks on finish and paces the digest bytes out.
// ---------------------------------------------------------------------------
module md5_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    input  md5_pkg::md5_sts_t sts,
    output md5_pkg::md5_cmd_t cmd
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFETCH,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    md5_mode_t  mode_reg, mode_next;
    logic [5:0] round_reg, round_next;
    logic [3:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        round_next = round_reg;
        idx_next   = idx_reg;

        cmd           = '0;
        cmd.mode      = mode_reg;
        cmd.round     = round_reg;
        cmd.rd_round  = (state_reg == ST_PREFETCH) ? 6'd0 : round_reg + 6'd1;
        cmd.out_idx   = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_cmd) begin
                        cmd.load_byte = 1'b1;
                        if (sts.blk_full) begin
                            mode_next  = BLK_DATA;
                            state_next = ST_PREFETCH;
                        end
                    end else begin
                        mode_next  = sts.pend_hi ? BLK_PAD_FIRST : BLK_PAD_ONE;
                        state_next = ST_PREFETCH;
                    end
                end
            end
            ST_PREFETCH: begin
                cmd.start_blk = 1'b1;
                round_next    = 6'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_SLOT) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                case (mode_reg)
                    BLK_DATA: begin
                        state_next = ST_IDLE;
                    end
                    BLK_PAD_FIRST: begin
                        mode_next  = BLK_PAD_LEN;
                        state_next = ST_PREFETCH;
                    end
                    default: begin
                        idx_next   = 4'd0;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == LAST_IDX) begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (state_reg == ST_EMIT) && (idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= BLK_DATA;
            round_reg <= 6'd0;
            idx_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== src/md5_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_datapath: block buffer, round unit and chaining state of the hasher
// Stores message bytes in a 16-word buffer, runs one MD5 round per cycle,
// builds the padding on the fly and selects the digest bytes.
// ---------------------------------------------------------------------------
module md5_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  md5_pkg::md5_cmd_t cmd,
    input  logic [7:0]        data_byte,
    output md5_pkg::md5_sts_t sts,
    output logic [7:0]        digest_byte
);
    import md5_pkg::*;

    logic [31:0] mem_reg [16];
    logic [31:0] rdata_reg;
    logic [3:0]  rword_reg;

    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [60:0] count_reg;   // message length in bytes, mod 2^61

    logic [5:0]  pend;
    logic [63:0] bit_len;
    logic [3:0]  raddr;
    logic [31:0] w, f, sum, rot;
    logic [63:0] rot_wide;

    assign pend    = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};
    assign raddr   = md5_g(cmd.rd_round);

    assign sts.pend_hi  = (pend >= LEN_START);
    assign sts.blk_full = (pend == LAST_SLOT);

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            mem_reg[pend[5:2]][pend[1:0]*8 +: 8] <= data_byte;
        end
        rdata_reg <= mem_reg[raddr];
        rword_reg <= raddr;
    end

    // Replace buffer bytes by padding and length bytes per block kind.
    always_comb begin
        logic [5:0] p;
        logic [7:0] mb;
        logic [7:0] lb;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            p  = {rword_reg, j[1:0]};
            mb = rdata_reg[j*8 +: 8];
            lb = bit_len[p[2:0]*8 +: 8];
            case (cmd.mode)
                BLK_DATA: begin
                    w[j*8 +: 8] = mb;
                end
                BLK_PAD_ONE: begin
                    if (p < pend)            w[j*8 +: 8] = mb;
                    else if (p == pend)      w[j*8 +: 8] = PAD_BYTE;
                    else if (p >= LEN_START) w[j*8 +: 8] = lb;
                    else                     w[j*8 +: 8] = 8'h00;
                end
                BLK_PAD_FIRST: begin
                    if (p < pend)            w[j*8 +: 8] = mb;
                    else if (p == pend)      w[j*8 +: 8] = PAD_BYTE;
                    else                     w[j*8 +: 8] = 8'h00;
                end
                default: begin
                    if (p >= LEN_START)      w[j*8 +: 8] = lb;
                    else                     w[j*8 +: 8] = 8'h00;
                end
            endcase
        end
    end

    always_comb begin
        case (cmd.round[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum      = a_reg + f + md5_k(cmd.round) + w;
        rot_wide = {sum, sum} << md5_s(cmd.round);
        rot      = rot_wide[63:32];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_blk) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.round_en) begin
            a_reg <= d_reg;
            b_reg <= b_reg + rot;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
            count_reg    <= '0;
        end else begin
            if (cmd.fold) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            if (cmd.load_byte) begin
                count_reg <= count_reg + 61'd1;
            end
        end
    end

    assign digest_byte = chain_reg[cmd.out_idx[3:2]][cmd.out_idx[1:0]*8 +: 8];

endmodule

// ===== src/md5_stream_hasher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_stream_hasher: byte-streaming MD5 message digest
// Absorbs message bytes, compresses each full 64-byte block and, on a
// finish item, pads the message and streams out the 16 digest bytes.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ---------------------------------------------------
//  s_       in         tdata[7:0] data_byte, tuser[0] cmd (1 = finish)
//  m_       out        tdata[7:0] digest_byte, tdata[11:8] byte_index,
//                      tlast = last digest byte
//
// A byte item is accepted on its handshake. The item that completes a block is
// followed by a phase with s_tready low: a word prefetch, 64 rounds of
// the single shared round unit, and a fold into the chaining words.
// A finish item costs one or two block compressions, then 16 digest items
// at the pace the sink takes them; s_tready stays low until the last one.
// Reset (aresetn low, synchronous) loads the initial chaining values and
// clears the length; the block buffer needs no clearing.
// ---------------------------------------------------------------------------
module md5_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] digest_byte, [11:8] byte_index
    output logic        m_tlast
);
    import md5_pkg::*;

    md5_cmd_t   cmd;
    md5_sts_t   sts;
    logic [7:0] digest_byte;

    // The controller sequences every item; the datapath only follows its
    // commands and reports how full the current block is.
    md5_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    md5_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .sts         (sts),
        .digest_byte (digest_byte)
    );

    // The digest byte and its index come straight from registers, so they
    // hold steady while the sink stalls.
    assign m_tdata = {4'b0000, cmd.out_idx, digest_byte};

endmodule
